[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared macros for the concurrent checks of the timer queue.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with an active-low reset that disables the check.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the standard clock and reset of this project.
`define STQ_ASSERT(label, prop, msg) \
  `ASSERT_CLK_RST(label, clk_i, rst_ni, prop, msg)

`endif

[rtl/stq_pkg.sv]
// ---------------------------------------------------------------------------
// Sorted timer queue package
// Item types, request and status codes, controller states and datapath ops.
// ---------------------------------------------------------------------------
package stq_pkg;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_ADJUST = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_TICK   = 2'd3
  } stq_req_e;

  // Status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ACTIVE   = 2'd1,
    ST_INACTIVE = 2'd2
  } stq_status_e;

  // One input item.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [5:0]  timer_id;
    logic [31:0] expire_time;
    logic [31:0] current_time;
  } stq_req_t;

  // One result item.
  typedef struct packed {
    logic [1:0] status;
    logic       expired_valid;
    logic [5:0] expired_id;
    logic       last;
  } stq_res_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_ADJ_PREV,
    S_ADJ_NEXT,
    S_ADJ_CMP,
    S_DEL_UNLINK,
    S_INS,
    S_INS_HEAD,
    S_WALK,
    S_WALK_Q,
    S_WALK_CMP,
    S_LINK_B,
    S_RESP,
    S_TICK,
    S_TICK_CMP
  } stq_state_e;

  // Datapath micro-operations.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_RD_LINKS,
    OP_RD_EXP_PREV,
    OP_RD_EXP_NEXT,
    OP_ADJ_WRITE,
    OP_UNLINK,
    OP_INS_START,
    OP_INS_FRONT,
    OP_WALK_INIT,
    OP_RD_NEXT_P,
    OP_RD_EXP_Q,
    OP_LINK_A,
    OP_LINK_B,
    OP_APPEND,
    OP_STEP,
    OP_TICK_RD,
    OP_TICK_POP,
    OP_TICK_END,
    OP_RESP
  } stq_op_e;

  // Command from controller to datapath.
  typedef struct packed {
    stq_op_e     op;
    stq_status_e status;
  } stq_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic [1:0] req_type;
    logic       in_range;
    logic       active;
    logic       empty;
    logic       p_is_tail;
    logic       t_lt_rd;
    logic       rd_le_cur;
    logic       prev_ok;
    logic       next_ok;
  } stq_flags_t;

endpackage

[rtl/stq_ctrl.sv]
// ---------------------------------------------------------------------------
// Timer queue controller
// Sequences each request as a series of datapath operations.
// ---------------------------------------------------------------------------
module stq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  stq_pkg::stq_flags_t flags_i,
  output stq_pkg::stq_cmd_t  cmd_o,
  output logic               busy_o
);
  import stq_pkg::*;

  stq_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and command.
  always_comb begin
    state_d     = state_q;
    cmd_o.op     = OP_NONE;
    cmd_o.status = ST_OK;
    busy_o       = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stq_req_e'(flags_i.req_type))
          REQ_ADD: begin
            if (!flags_i.in_range) begin
              cmd_o.op     = OP_RESP;
              cmd_o.status = ST_INACTIVE;
              state_d      = S_IDLE;
            end else if (flags_i.active) begin
              cmd_o.op     = OP_RESP;
              cmd_o.status = ST_ACTIVE;
              state_d      = S_IDLE;
            end else begin
              cmd_o.op = OP_INS_START;
              state_d  = flags_i.empty ? S_RESP : S_INS_HEAD;
            end
          end
          REQ_ADJUST, REQ_DELETE: begin
            if (!flags_i.active) begin
              cmd_o.op     = OP_RESP;
              cmd_o.status = ST_INACTIVE;
              state_d      = S_IDLE;
            end else begin
              cmd_o.op = OP_RD_LINKS;
              state_d  = (flags_i.req_type == REQ_ADJUST) ? S_ADJ_PREV : S_DEL_UNLINK;
            end
          end
          default: begin
            state_d = S_TICK;
          end
        endcase
      end
      S_ADJ_PREV: begin
        cmd_o.op = OP_RD_EXP_PREV;
        state_d  = S_ADJ_NEXT;
      end
      S_ADJ_NEXT: begin
        cmd_o.op = OP_RD_EXP_NEXT;
        state_d  = S_ADJ_CMP;
      end
      S_ADJ_CMP: begin
        // Keep the place when the new time still fits between the neighbors.
        if (flags_i.prev_ok && flags_i.next_ok) begin
          cmd_o.op = OP_ADJ_WRITE;
          state_d  = S_RESP;
        end else begin
          cmd_o.op = OP_UNLINK;
          state_d  = S_INS;
        end
      end
      S_DEL_UNLINK: begin
        cmd_o.op = OP_UNLINK;
        state_d  = S_RESP;
      end
      S_INS: begin
        cmd_o.op = OP_INS_START;
        state_d  = flags_i.empty ? S_RESP : S_INS_HEAD;
      end
      S_INS_HEAD: begin
        if (flags_i.t_lt_rd) begin
          cmd_o.op = OP_INS_FRONT;
          state_d  = S_RESP;
        end else begin
          cmd_o.op = OP_WALK_INIT;
          state_d  = S_WALK;
        end
      end
      S_WALK: begin
        if (flags_i.p_is_tail) begin
          cmd_o.op = OP_APPEND;
          state_d  = S_RESP;
        end else begin
          cmd_o.op = OP_RD_NEXT_P;
          state_d  = S_WALK_Q;
        end
      end
      S_WALK_Q: begin
        cmd_o.op = OP_RD_EXP_Q;
        state_d  = S_WALK_CMP;
      end
      S_WALK_CMP: begin
        if (flags_i.t_lt_rd) begin
          cmd_o.op = OP_LINK_A;
          state_d  = S_LINK_B;
        end else begin
          cmd_o.op = OP_STEP;
          state_d  = S_WALK;
        end
      end
      S_LINK_B: begin
        cmd_o.op = OP_LINK_B;
        state_d  = S_RESP;
      end
      S_RESP: begin
        cmd_o.op = OP_RESP;
        state_d  = S_IDLE;
      end
      S_TICK: begin
        if (flags_i.empty) begin
          cmd_o.op = OP_TICK_END;
          state_d  = S_IDLE;
        end else begin
          cmd_o.op = OP_TICK_RD;
          state_d  = S_TICK_CMP;
        end
      end
      S_TICK_CMP: begin
        if (flags_i.rd_le_cur) begin
          cmd_o.op = OP_TICK_POP;
          state_d  = S_TICK;
        end else begin
          cmd_o.op = OP_TICK_END;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/stq_dp.sv]
// ---------------------------------------------------------------------------
// Timer queue datapath
// Expiry and link memories, list pointers, compares and result register.
// ---------------------------------------------------------------------------
module stq_dp #(
  parameter int NUM_TIMERS = 64,
  parameter int TIME_BITS  = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  stq_pkg::stq_cmd_t   cmd_i,
  input  stq_pkg::stq_req_t   req_i,
  output stq_pkg::stq_flags_t flags_o,
  output logic                res_valid_o,
  output stq_pkg::stq_res_t   result_o
);
  import stq_pkg::*;

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int ACT_N = (NUM_TIMERS < 64) ? NUM_TIMERS : 64;
  localparam int ACT_W = (ACT_N > 1) ? $clog2(ACT_N) : 1;

  // Latched request.
  logic [1:0]           type_q, type_d;
  logic [5:0]           id_q, id_d;
  logic [TIME_BITS-1:0] t_q, t_d, cur_q, cur_d;

  // List state.
  logic [IDX_W-1:0] head_q, head_d, tail_q, tail_d;
  logic             empty_q, empty_d;
  logic [ACT_N-1:0] act_q, act_d;
  logic [IDX_W-1:0] p_q, p_d, q_q, q_d;
  logic             pend_q, pend_d;
  logic [IDX_W-1:0] pend_id_q, pend_id_d;
  logic             prev_ok_q, prev_ok_d;
  logic             res_vld_q, res_vld_d;
  stq_res_t         res_q, res_d;

  // Memories.
  logic [TIME_BITS-1:0] exp_mem [NUM_TIMERS];
  logic [IDX_W-1:0]     nxt_mem [NUM_TIMERS];
  logic [IDX_W-1:0]     prv_mem [NUM_TIMERS];
  logic [TIME_BITS-1:0] exp_rd_q;
  logic [IDX_W-1:0]     nxt_rd_q, prv_rd_q;

  logic                 exp_we, exp_re, nxt_we, prv_we, lnk_re;
  logic [IDX_W-1:0]     exp_wa, exp_ra, nxt_wa, prv_wa, lnk_ra;
  logic [TIME_BITS-1:0] exp_wd;
  logic [IDX_W-1:0]     nxt_wd, prv_wd;

  logic [IDX_W-1:0] id_idx;
  logic [ACT_W-1:0] id_act, head_act;
  logic             in_range, id_is_head, id_is_tail, t_lt_rd;

  assign id_idx     = IDX_W'(id_q);
  assign id_act     = ACT_W'(id_q);
  assign head_act   = ACT_W'(head_q);
  assign in_range   = 32'(id_q) < 32'(NUM_TIMERS);
  assign id_is_head = (id_idx == head_q);
  assign id_is_tail = (id_idx == tail_q);
  assign t_lt_rd    = (t_q < exp_rd_q);

  // Status toward the controller.
  always_comb begin
    flags_o.req_type  = type_q;
    flags_o.in_range  = in_range;
    flags_o.active    = in_range && act_q[id_act];
    flags_o.empty     = empty_q;
    flags_o.p_is_tail = (p_q == tail_q);
    flags_o.t_lt_rd   = t_lt_rd;
    flags_o.rd_le_cur = (exp_rd_q <= cur_q);
    flags_o.prev_ok   = prev_ok_q;
    flags_o.next_ok   = id_is_tail || t_lt_rd;
  end

  // Operation decode.
  always_comb begin
    type_d    = type_q;
    id_d      = id_q;
    t_d       = t_q;
    cur_d     = cur_q;
    head_d    = head_q;
    tail_d    = tail_q;
    empty_d   = empty_q;
    act_d     = act_q;
    p_d       = p_q;
    q_d       = q_q;
    pend_d    = pend_q;
    pend_id_d = pend_id_q;
    prev_ok_d = prev_ok_q;
    res_vld_d = 1'b0;
    res_d     = res_q;
    exp_we    = 1'b0;
    exp_re    = 1'b0;
    nxt_we    = 1'b0;
    prv_we    = 1'b0;
    lnk_re    = 1'b0;
    exp_wa    = id_idx;
    exp_ra    = head_q;
    nxt_wa    = id_idx;
    prv_wa    = id_idx;
    lnk_ra    = id_idx;
    exp_wd    = t_q;
    nxt_wd    = head_q;
    prv_wd    = id_idx;
    case (cmd_i.op)
      OP_LATCH: begin
        type_d = req_i.req_type;
        id_d   = req_i.timer_id;
        t_d    = TIME_BITS'(req_i.expire_time);
        cur_d  = TIME_BITS'(req_i.current_time);
        pend_d = 1'b0;
      end
      OP_RD_LINKS: begin
        lnk_re = 1'b1;
        lnk_ra = id_idx;
      end
      OP_RD_EXP_PREV: begin
        exp_re = 1'b1;
        exp_ra = prv_rd_q;
      end
      OP_RD_EXP_NEXT: begin
        prev_ok_d = id_is_head || (exp_rd_q <= t_q);
        exp_re    = 1'b1;
        exp_ra    = nxt_rd_q;
      end
      OP_ADJ_WRITE: begin
        exp_we = 1'b1;
      end
      OP_UNLINK: begin
        // Take the timer out, patching its neighbors or the end pointers.
        if (id_is_head && id_is_tail) begin
          empty_d = 1'b1;
        end else if (id_is_head) begin
          head_d = nxt_rd_q;
        end else if (id_is_tail) begin
          tail_d = prv_rd_q;
        end else begin
          nxt_we = 1'b1;
          nxt_wa = prv_rd_q;
          nxt_wd = nxt_rd_q;
          prv_we = 1'b1;
          prv_wa = nxt_rd_q;
          prv_wd = prv_rd_q;
        end
        act_d[id_act] = 1'b0;
      end
      OP_INS_START: begin
        exp_we        = 1'b1;
        act_d[id_act] = 1'b1;
        if (empty_q) begin
          head_d  = id_idx;
          tail_d  = id_idx;
          empty_d = 1'b0;
        end else begin
          exp_re = 1'b1;
          exp_ra = head_q;
        end
      end
      OP_INS_FRONT: begin
        nxt_we = 1'b1;
        nxt_wa = id_idx;
        nxt_wd = head_q;
        prv_we = 1'b1;
        prv_wa = head_q;
        prv_wd = id_idx;
        head_d = id_idx;
      end
      OP_WALK_INIT: begin
        p_d = head_q;
      end
      OP_RD_NEXT_P: begin
        lnk_re = 1'b1;
        lnk_ra = p_q;
      end
      OP_RD_EXP_Q: begin
        q_d    = nxt_rd_q;
        exp_re = 1'b1;
        exp_ra = nxt_rd_q;
      end
      OP_LINK_A: begin
        nxt_we = 1'b1;
        nxt_wa = p_q;
        nxt_wd = id_idx;
        prv_we = 1'b1;
        prv_wa = id_idx;
        prv_wd = p_q;
      end
      OP_LINK_B: begin
        nxt_we = 1'b1;
        nxt_wa = id_idx;
        nxt_wd = q_q;
        prv_we = 1'b1;
        prv_wa = q_q;
        prv_wd = id_idx;
      end
      OP_APPEND: begin
        nxt_we = 1'b1;
        nxt_wa = tail_q;
        nxt_wd = id_idx;
        prv_we = 1'b1;
        prv_wa = id_idx;
        prv_wd = tail_q;
        tail_d = id_idx;
      end
      OP_STEP: begin
        p_d = q_q;
      end
      OP_TICK_RD: begin
        exp_re = 1'b1;
        exp_ra = head_q;
        lnk_re = 1'b1;
        lnk_ra = head_q;
      end
      OP_TICK_POP: begin
        // The previous expired timer is now known not to be the last one.
        if (pend_q) begin
          res_vld_d           = 1'b1;
          res_d.status        = ST_OK;
          res_d.expired_valid = 1'b1;
          res_d.expired_id    = 6'(pend_id_q);
          res_d.last          = 1'b0;
        end
        pend_d    = 1'b1;
        pend_id_d = head_q;
        if (head_q == tail_q) begin
          empty_d = 1'b1;
        end else begin
          head_d = nxt_rd_q;
        end
        act_d[head_act] = 1'b0;
      end
      OP_TICK_END: begin
        res_vld_d           = 1'b1;
        res_d.status        = ST_OK;
        res_d.expired_valid = pend_q;
        res_d.expired_id    = pend_q ? 6'(pend_id_q) : 6'd0;
        res_d.last          = 1'b1;
        pend_d              = 1'b0;
      end
      OP_RESP: begin
        res_vld_d           = 1'b1;
        res_d.status        = cmd_i.status;
        res_d.expired_valid = 1'b0;
        res_d.expired_id    = 6'd0;
        res_d.last          = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      empty_q   <= 1'b1;
      act_q     <= '0;
      pend_q    <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      empty_q   <= empty_d;
      act_q     <= act_d;
      pend_q    <= pend_d;
      res_vld_q <= res_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    type_q    <= type_d;
    id_q      <= id_d;
    t_q       <= t_d;
    cur_q     <= cur_d;
    p_q       <= p_d;
    q_q       <= q_d;
    pend_id_q <= pend_id_d;
    prev_ok_q <= prev_ok_d;
    res_q     <= res_d;
  end

  // Expiry memory.
  always_ff @(posedge clk_i) begin
    if (exp_we) begin
      exp_mem[exp_wa] <= exp_wd;
    end
    if (exp_re) begin
      exp_rd_q <= exp_mem[exp_ra];
    end
  end

  // Next-link memory.
  always_ff @(posedge clk_i) begin
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    if (lnk_re) begin
      nxt_rd_q <= nxt_mem[lnk_ra];
    end
  end

  // Previous-link memory.
  always_ff @(posedge clk_i) begin
    if (prv_we) begin
      prv_mem[prv_wa] <= prv_wd;
    end
    if (lnk_re) begin
      prv_rd_q <= prv_mem[lnk_ra];
    end
  end

  assign res_valid_o = res_vld_q;
  assign result_o    = res_q;

endmodule

[rtl/sorted_timer_queue.sv]
// ---------------------------------------------------------------------------
// Sorted timer queue
// Timers kept in a linked list sorted by expiry, with add, adjust, delete, tick.
// ---------------------------------------------------------------------------
// Each request runs as a series of datapath steps: errors answer straight from
// dispatch, delete unlinks the timer, add walks the list entry by entry through
// the one-port memories; adjust writes in place if the new time still fits, else
// unlinks and adds. Tick pops expired timers from the head with one result each,
// or gives one plain result when none expires. One item at a time; busy drops as the last
// result shows and results cannot be stalled. Reset empties the list at once.
module sorted_timer_queue #(
  parameter int NUM_TIMERS = 64,
  parameter int TIME_BITS  = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  stq_pkg::stq_req_t req_i,
  output logic              res_valid_o,
  output stq_pkg::stq_res_t result_o
);
  import stq_pkg::*;

  stq_cmd_t   cmd;
  stq_flags_t flags;

  // Request sequencer.
  stq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .flags_i (flags),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // List storage and result register.
  stq_dp #(
    .NUM_TIMERS (NUM_TIMERS),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .flags_o     (flags),
    .res_valid_o (res_valid_o),
    .result_o    (result_o)
  );

endmodule

[rtl/stq_checker.sv]
// ---------------------------------------------------------------------------
// Timer queue checker
// Port-level checks on request acceptance and result sequencing.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module stq_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input stq_pkg::stq_req_t req_i,
  input logic              res_valid_o,
  input stq_pkg::stq_res_t result_o
);
  import stq_pkg::*;

  logic res_err;

  // A result that carries an error status.
  assign res_err = res_valid_o && (result_o.status != ST_OK);

  // An accepted item keeps the block busy in the next cycle.
  `STQ_ASSERT(a_accept_busy, start && !busy |=> busy, "busy did not rise after an item")

  // Results only come from work that was under way.
  `STQ_ASSERT(a_res_from_busy, res_valid_o |-> $past(busy), "result without an item in work")

  // More results are due after a result that is not the last one.
  `STQ_ASSERT(a_more_busy, res_valid_o && !result_o.last |-> busy, "idle before last result")

  // An error answer is a single plain result.
  `STQ_ASSERT(a_err_plain, res_err |-> !result_o.expired_valid && result_o.last, "bad error result")

  // A result without an expired timer always closes its item.
  `STQ_ASSERT(a_plain_last, res_valid_o && !result_o.expired_valid |-> result_o.last, "plain result not last")

endmodule

bind sorted_timer_queue stq_checker u_stq_checker (.*);

[bench/sorted_timer_queue_tb.sv]
// ---------------------------------------------------------------------------
// Sorted timer queue testbench
// Drives add, adjust, delete and tick requests from a directed table and then
// from random timer traffic, predicts every result with a software copy of
// the sorted list, and compares each result field by field in order.
// ---------------------------------------------------------------------------
module sorted_timer_queue_tb;
  import stq_pkg::*;

  localparam int NT = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  // Directed row: request plus an optional hand-written expected first result.
  typedef struct packed {
    stq_req_t req;
    logic     has_exp;
    stq_res_t exp;
  } dir_row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  stq_req_t req_i = '0;
  logic     res_valid_o;
  stq_res_t result_o;

  sorted_timer_queue #(.NUM_TIMERS(NT), .TIME_BITS(32)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .result_o   (result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted timer list state.
  logic [31:0] exp_at[NT];
  logic        armed[NT];
  logic [5:0]  nxt[NT];
  logic [5:0]  prv[NT];
  logic [5:0]  head_id, tail_id;
  logic        no_timers;

  stq_res_t pending_results[$];
  int       mismatches = 0;
  int       idle_cycles = 0;

  function automatic stq_res_t mk_res(stq_status_e st, logic v, logic [5:0] id, logic l);
    stq_res_t r;
    r.status = st;
    r.expired_valid = v;
    r.expired_id = id;
    r.last = l;
    return r;
  endfunction

  function automatic void drop_timer(logic [5:0] id);
    if (head_id == id && tail_id == id) begin
      no_timers = 1'b1;
    end else if (head_id == id) begin
      head_id = nxt[id];
    end else if (tail_id == id) begin
      tail_id = prv[id];
    end else begin
      nxt[prv[id]] = nxt[id];
      prv[nxt[id]] = prv[id];
    end
    armed[id] = 1'b0;
  endfunction

  function automatic void place_timer(logic [5:0] id, logic [31:0] t);
    logic [5:0] p, q;
    exp_at[id] = t;
    armed[id] = 1'b1;
    if (no_timers) begin
      head_id = id;
      tail_id = id;
      no_timers = 1'b0;
      return;
    end
    if (t < exp_at[head_id]) begin
      nxt[id] = head_id;
      prv[head_id] = id;
      head_id = id;
      return;
    end
    p = head_id;
    for (int n = 0; n < NT; n++) begin
      if (p == tail_id) break;
      q = nxt[p];
      if (t < exp_at[q]) begin
        nxt[p] = id;
        prv[id] = p;
        nxt[id] = q;
        prv[q] = id;
        return;
      end
      p = q;
    end
    nxt[tail_id] = id;
    prv[id] = tail_id;
    tail_id = id;
  endfunction

  // Apply one request to the predicted list and queue its results.
  function automatic void predict_timer_req(stq_req_t r);
    logic [5:0] id;
    logic       prev_ok, next_ok;
    int         k;
    id = r.timer_id;
    if (r.req_type == REQ_TICK) begin
      k = 0;
      while (!no_timers && k < NT && exp_at[head_id] <= r.current_time) begin
        id = head_id;
        drop_timer(id);
        pending_results.push_back(mk_res(ST_OK, 1'b1, id, 1'b0));
        k++;
      end
      if (k == 0) pending_results.push_back(mk_res(ST_OK, 1'b0, '0, 1'b1));
      else pending_results[$].last = 1'b1;
    end else if (r.req_type == REQ_ADD) begin
      if (armed[id]) begin
        pending_results.push_back(mk_res(ST_ACTIVE, 1'b0, '0, 1'b1));
      end else begin
        place_timer(id, r.expire_time);
        pending_results.push_back(mk_res(ST_OK, 1'b0, '0, 1'b1));
      end
    end else if (!armed[id]) begin
      pending_results.push_back(mk_res(ST_INACTIVE, 1'b0, '0, 1'b1));
    end else begin
      if (r.req_type == REQ_ADJUST) begin
        prev_ok = (id == head_id) || (exp_at[prv[id]] <= r.expire_time);
        next_ok = (id == tail_id) || (r.expire_time < exp_at[nxt[id]]);
        if (prev_ok && next_ok) begin
          exp_at[id] = r.expire_time;
        end else begin
          drop_timer(id);
          place_timer(id, r.expire_time);
        end
      end else begin
        drop_timer(id);
      end
      pending_results.push_back(mk_res(ST_OK, 1'b0, '0, 1'b1));
    end
  endfunction

  function automatic stq_req_t mk_req(stq_req_e op, logic [5:0] id, logic [31:0] t,
                                      logic [31:0] cur);
    stq_req_t r;
    r.req_type = op;
    r.timer_id = id;
    r.expire_time = t;
    r.current_time = cur;
    return r;
  endfunction

  // Result checker: results cannot be held off, so every strobe is taken.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result_o);
      end else begin
        stq_res_t e;
        e = pending_results.pop_front();
        if (result_o.status !== e.status || result_o.expired_valid !== e.expired_valid ||
            result_o.expired_id !== e.expired_id || result_o.last !== e.last) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p, got %p", e, result_o);
        end
      end
    end
  end

  // Watchdog over cycles in which no item and no result is accepted.
  always @(posedge clk_i) begin
    if (!rst_ni || res_valid_o || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("sorted_timer_queue_tb: done, errors");
      $finish;
    end
  end

  // Present one item, hold it until accepted, predict it, then maybe gap.
  stq_res_t first_pred;
  int       burst_left = 0;
  task automatic send_item(stq_req_t r);
    int n_before;
    int gap;
    req_i <= r;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    n_before = pending_results.size();
    predict_timer_req(r);
    first_pred = pending_results[n_before];
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(0, 8);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Random timer traffic concentrated on a small id pool and a time window.
  logic [31:0] now_s = 32'd1000;
  function automatic stq_req_t rand_req();
    int sel;
    logic [5:0]  id;
    logic [31:0] t;
    sel = $urandom_range(0, 99);
    id = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 15));
    t = now_s + $urandom_range(0, 200);
    if ($urandom_range(0, 19) == 0) t = $urandom;
    if (sel < 40) return mk_req(REQ_ADD, id, t, $urandom);
    if (sel < 60) return mk_req(REQ_ADJUST, id, t, $urandom);
    if (sel < 72) return mk_req(REQ_DELETE, id, $urandom, $urandom);
    now_s = now_s + $urandom_range(0, 60);
    return mk_req(REQ_TICK, 6'($urandom), $urandom,
                  ($urandom_range(0, 29) == 0) ? $urandom : now_s);
  endfunction

  dir_row_t directed[21] = '{
    '{mk_req(REQ_TICK, 6'd0, 32'd0, 32'hFFFF_FFFF), 1'b1, '{ST_OK, 1'b0, 6'd0, 1'b1}},
    '{mk_req(REQ_DELETE, 6'd5, 32'd0, 32'd0), 1'b1, '{ST_INACTIVE, 1'b0, 6'd0, 1'b1}},
    '{mk_req(REQ_ADJUST, 6'd63, 32'd7, 32'd0), 1'b1, '{ST_INACTIVE, 1'b0, 6'd0, 1'b1}},
    '{mk_req(REQ_ADD, 6'd0, 32'd0, 32'd0), 1'b1, '{ST_OK, 1'b0, 6'd0, 1'b1}},
    '{mk_req(REQ_ADD, 6'd0, 32'd9, 32'd0), 1'b1, '{ST_ACTIVE, 1'b0, 6'd0, 1'b1}},
    '{mk_req(REQ_ADD, 6'd63, 32'hFFFF_FFFF, 32'd0), 1'b1, '{ST_OK, 1'b0, 6'd0, 1'b1}},
    '{mk_req(REQ_ADD, 6'd10, 32'd50, 32'd0), 1'b0, '0},
    '{mk_req(REQ_ADD, 6'd11, 32'd50, 32'd0), 1'b0, '0},
    '{mk_req(REQ_ADD, 6'd12, 32'd20, 32'd0), 1'b0, '0},
    '{mk_req(REQ_ADD, 6'd13, 32'd50, 32'hFFFF_FFFF), 1'b0, '0},
    '{mk_req(REQ_ADJUST, 6'd12, 32'd30, 32'd0), 1'b0, '0},
    '{mk_req(REQ_ADJUST, 6'd10, 32'd70, 32'd0), 1'b0, '0},
    '{mk_req(REQ_ADJUST, 6'd13, 32'd1, 32'd0), 1'b0, '0},
    '{mk_req(REQ_ADJUST, 6'd63, 32'hFFFF_FFFE, 32'd0), 1'b0, '0},
    '{mk_req(REQ_DELETE, 6'd11, 32'd0, 32'd0), 1'b0, '0},
    '{mk_req(REQ_TICK, 6'd0, 32'd0, 32'd0), 1'b1, '{ST_OK, 1'b1, 6'd0, 1'b1}},
    '{mk_req(REQ_TICK, 6'd0, 32'd0, 32'd30), 1'b0, '0},
    '{mk_req(REQ_ADD, 6'd11, 32'd70, 32'd0), 1'b0, '0},
    '{mk_req(REQ_TICK, 6'h2A, 32'hAAAA_AAAA, 32'd69), 1'b1, '{ST_OK, 1'b0, 6'd0, 1'b1}},
    '{mk_req(REQ_TICK, 6'h15, 32'h5555_5555, 32'hFFFF_FFFF), 1'b0, '0},
    '{mk_req(REQ_DELETE, 6'd63, 32'd0, 32'd0), 1'b1, '{ST_INACTIVE, 1'b0, 6'd0, 1'b1}}
  };

  initial begin
    no_timers = 1'b1;
    head_id = '0;
    tail_id = '0;
    for (int i = 0; i < NT; i++) armed[i] = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; typed-in rows are checked against the prediction too.
    foreach (directed[i]) begin
      send_item(directed[i].req);
      if (directed[i].has_exp && first_pred !== directed[i].exp) begin
        mismatches++;
        if (mismatches <= 10)
          $display("row %0d: table %p, prediction %p", i, directed[i].exp, first_pred);
      end
    end
    drain_results();

    // Random traffic; one full pause halfway through.
    for (int n = 0; n < 400; n++) begin
      if (n == 200) drain_results();
      send_item(rand_req());
    end
    // Flush every timer so ticks with many results are also seen.
    send_item(mk_req(REQ_TICK, 6'd0, 32'd0, 32'hFFFF_FFFF));
    drain_results();
    repeat (20) @(posedge clk_i);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("sorted_timer_queue_tb: done, clean");
    end else begin
      $display("sorted_timer_queue_tb: done, errors");
    end
    $finish;
  end
endmodule
